// ----- hdl/gasc_pkg.sv -----
// ----------------------------------------------------------------------------
// gasc_pkg: shared types and constants
// Field widths, status codes and register indexes of the step checker.
// ----------------------------------------------------------------------------
package gasc_pkg;

  localparam int CellW  = 12;
  localparam int Cells  = 4096;
  localparam int AgentW = 10;
  localparam int OffW   = 14;
  localparam int DimW   = 7;
  localparam int QDepth = 2;

  typedef enum logic [3:0] {
    ST_OK        = 4'd0,
    ST_ROTATE    = 4'd1,
    ST_MOVE_ROT  = 4'd2,
    ST_WRONG_DIR = 4'd3,
    ST_TOO_FAR   = 4'd4,
    ST_OBSTACLE  = 4'd5,
    ST_VERTEX    = 4'd6,
    ST_EDGE      = 4'd7,
    ST_SKIPPED   = 4'd8
  } status_e;

  typedef enum logic [2:0] {
    REG_ROWS = 3'd0,
    REG_COLS = 3'd1,
    REG_OFF0 = 3'd2,
    REG_OFF1 = 3'd3,
    REG_OFF2 = 3'd4,
    REG_OFF3 = 3'd5
  } reg_e;

  // item passed from the classifier to the table stage
  typedef struct packed {
    logic              load;
    logic              blocked;
    logic [CellW-1:0]  prev;
    logic [CellW-1:0]  next;
    logic [3:0]        pre_status;  // ST_OK when motion checks passed
    logic              off_map;
    logic [15:0]       tstamp;
    logic              last;
  } item_t;

  typedef enum logic [2:0] {
    B_IDLE, B_CLEAR, B_RD, B_WAIT, B_EVAL, B_OUT
  } back_e;

endpackage

// ----- hdl/gasc_ram.sv -----
// ----------------------------------------------------------------------------
// gasc_ram: generic single-port ram
// One write or read per cycle, registered read data.
// ----------------------------------------------------------------------------
module gasc_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[addr_i] <= wdata_i;
    rdata_o <= mem_q[addr_i];
  end

endmodule

// ----- hdl/gasc_front.sv -----
// ----------------------------------------------------------------------------
// gasc_front: classifier
// Runs the motion checks of a transfer; column division is a serial
// subtract loop, one quotient bit a cycle.
// ----------------------------------------------------------------------------
module gasc_front
  import gasc_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  item_t                 in_item_i,
  input  logic [1:0]            ph_i,
  input  logic [1:0]            nh_i,
  input  logic [DimW-1:0]       rows_i,
  input  logic [DimW-1:0]       cols_i,
  input  logic signed [OffW-1:0] off_i [4],
  output logic                  q_valid_o,
  input  logic                  q_ready_i,
  output item_t                 q_item_o
);

  // divide prev and next by cols in parallel, restoring, 12 steps
  logic              busy_q, busy_d, done_q, done_d;
  logic [3:0]        cnt_q, cnt_d;
  item_t             it_q, it_d;
  logic [CellW-1:0]  np_q, np_d, nn_q, nn_d;   // dividend shift
  logic [DimW-1:0]   rp_q, rp_d, rn_q, rn_d;   // remainders
  logic [CellW-1:0]  qp_q, qp_d, qn_q, qn_d;
  logic [DimW-1:0]   cols;
  logic [DimW-1:0]   rows;
  logic [DimW:0]     tp, tn;
  logic signed [CellW+1:0] dq, dr;
  logic signed [CellW+1:0] diff;
  logic [13:0]       area;
  logic [3:0]        st;

  assign cols = (cols_i == '0) ? DimW'(1) : cols_i;
  assign rows = (rows_i == '0) ? DimW'(1) : rows_i;
  assign tp = {rp_q, np_q[CellW-1]};
  assign tn = {rn_q, nn_q[CellW-1]};

  assign in_ready_o = !busy_q && !done_q;
  assign q_valid_o  = done_q;

  always_comb begin
    busy_d = busy_q; done_d = done_q; cnt_d = cnt_q; it_d = it_q;
    np_d = np_q; nn_d = nn_q; rp_d = rp_q; rn_d = rn_q; qp_d = qp_q; qn_d = qn_q;
    dq = '0; dr = '0; diff = '0; area = '0; st = ST_OK;
    if (in_valid_i && in_ready_o) begin
      it_d = in_item_i;
      np_d = in_item_i.prev; nn_d = in_item_i.next;
      rp_d = '0; rn_d = '0; qp_d = '0; qn_d = '0; cnt_d = '0;
      // motion checks that need no division
      diff = $signed({2'b0, in_item_i.next}) - $signed({2'b0, in_item_i.prev});
      if (in_item_i.prev == in_item_i.next) begin
        if (2'(ph_i - nh_i) == 2'd2) st = ST_ROTATE;
      end else if (ph_i != nh_i) begin
        st = ST_MOVE_ROT;
      end else if (diff != (CellW+2)'(off_i[ph_i])) begin
        st = ST_WRONG_DIR;
      end
      it_d.pre_status = st;
      area = 14'(rows) * 14'(cols);
      it_d.off_map = {2'b0, in_item_i.next} >= area;
      if (in_item_i.load) done_d = 1'b1;
      else busy_d = 1'b1;
    end else if (busy_q) begin
      np_d = np_q << 1; nn_d = nn_q << 1;
      if (tp >= {1'b0, cols}) begin rp_d = DimW'(tp - {1'b0, cols}); qp_d = {qp_q[CellW-2:0], 1'b1}; end
      else begin rp_d = tp[DimW-1:0]; qp_d = {qp_q[CellW-2:0], 1'b0}; end
      if (tn >= {1'b0, cols}) begin rn_d = DimW'(tn - {1'b0, cols}); qn_d = {qn_q[CellW-2:0], 1'b1}; end
      else begin rn_d = tn[DimW-1:0]; qn_d = {qn_q[CellW-2:0], 1'b0}; end
      cnt_d = cnt_q + 4'd1;
      if (cnt_q == 4'(CellW-1)) begin busy_d = 1'b0; done_d = 1'b1; end
    end else if (done_q && q_ready_i) begin
      done_d = 1'b0;
    end
    // distance check once quotients are known
    if (done_q && !it_q.load && it_q.pre_status == ST_OK && it_q.prev != it_q.next) begin
      dq = $signed({2'b0, qn_q}) - $signed({2'b0, qp_q});
      dr = $signed({7'b0, rn_q}) - $signed({7'b0, rp_q});
      if (dq < 0) dq = -dq;
      if (dr < 0) dr = -dr;
    end
  end

  always_comb begin
    q_item_o = it_q;
    if (dq + dr > 1) q_item_o.pre_status = ST_TOO_FAR;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0; done_q <= 1'b0; cnt_q <= '0;
    end else begin
      busy_q <= busy_d; done_q <= done_d; cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    it_q <= it_d; np_q <= np_d; nn_q <= nn_d; rp_q <= rp_d; rn_q <= rn_d;
    qp_q <= qp_d; qn_q <= qn_d;
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) !(busy_q && done_q))
    else $error("divider busy while result held");

endmodule

// ----- hdl/gasc_queue.sv -----
// ----------------------------------------------------------------------------
// gasc_queue: item fifo
// Short queue between classifier and table stage.
// ----------------------------------------------------------------------------
module gasc_queue
  import gasc_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  output logic  full_o,
  input  item_t data_i,
  input  logic  pop_i,
  output logic  empty_o,
  output item_t data_o
);

  item_t       buf_q [QDepth];
  logic        wp_q, rp_q;
  logic [1:0]  cnt_q;

  assign full_o  = cnt_q == 2'(QDepth);
  assign empty_o = cnt_q == '0;
  assign data_o  = buf_q[rp_q];

  always_ff @(posedge clk_i) if (push_i && !full_o) buf_q[wp_q] <= data_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0; rp_q <= 1'b0; cnt_q <= '0;
    end else begin
      if (push_i && !full_o) wp_q <= !wp_q;
      if (pop_i && !empty_o) rp_q <= !rp_q;
      cnt_q <= cnt_q + 2'(push_i && !full_o) - 2'(pop_i && !empty_o);
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q <= 2'(QDepth))
    else $error("queue count overflow");

endmodule

// ----- hdl/gasc_back.sv -----
// ----------------------------------------------------------------------------
// gasc_back: table stage
// Holds the obstacle map and occupancy table; reads next and prev cells,
// decides vertex and edge conflicts and updates the table.
// ----------------------------------------------------------------------------
module gasc_back
  import gasc_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               q_empty_i,
  input  item_t              q_item_i,
  output logic               q_pop_o,
  output logic               m_tvalid_o,
  input  logic               m_tready_i,
  output logic [3:0]         status_o,
  output logic [AgentW-1:0]  agent_o,
  output logic [AgentW-1:0]  other_o,
  output logic [15:0]        time_o,
  output logic               eos_o,
  output logic               ok_o
);

  back_e st_q, st_d;
  logic [CellW-1:0] addr_q, addr_d;   // clear sweep / read address
  logic             phase_q, phase_d; // 0 reads next cell, 1 reads prev cell
  logic [AgentW-1:0] cnt_q, cnt_d;
  logic             fail_q, fail_d;
  logic [3:0]       stat_q, stat_d;
  logic [AgentW-1:0] oth_q, oth_d;
  logic             eos_q, ok_q, eos_d, ok_d;
  logic [15:0]      tm_q, tm_d;
  logic [AgentW-1:0] idx_q, idx_d;
  logic             nblk_q, nblk_d, ntak_q, ntak_d;
  logic [AgentW-1:0] nown_q, nown_d;

  // rams: obstacle, taken (with epoch-free clear sweep), owner+came_from
  logic             ob_we, tk_we, oc_we;
  logic [CellW-1:0] ob_a, tk_a, oc_a;
  logic             ob_wd, tk_wd, ob_rd, tk_rd;
  logic [AgentW+CellW-1:0] oc_wd, oc_rd;
  logic             clr_q, clr_d; // table clear pending
  logic             init_q, init_d; // first sweep after reset also frees the obstacle map

  gasc_ram #(.Width(1), .Depth(Cells)) u_ob (.clk_i, .we_i(ob_we), .addr_i(ob_a),
    .wdata_i(ob_wd), .rdata_o(ob_rd));
  gasc_ram #(.Width(1), .Depth(Cells)) u_tk (.clk_i, .we_i(tk_we), .addr_i(tk_a),
    .wdata_i(tk_wd), .rdata_o(tk_rd));
  gasc_ram #(.Width(AgentW+CellW), .Depth(Cells)) u_oc (.clk_i, .we_i(oc_we),
    .addr_i(oc_a), .wdata_i(oc_wd), .rdata_o(oc_rd));

  item_t it;
  assign it = q_item_i;

  always_comb begin
    st_d = st_q; addr_d = addr_q; phase_d = phase_q; cnt_d = cnt_q; fail_d = fail_q;
    stat_d = stat_q; oth_d = oth_q; eos_d = eos_q; ok_d = ok_q; tm_d = tm_q;
    idx_d = idx_q; nblk_d = nblk_q; ntak_d = ntak_q; nown_d = nown_q; clr_d = clr_q;
    init_d = init_q;
    ob_we = 1'b0; tk_we = 1'b0; oc_we = 1'b0;
    ob_a = it.next; tk_a = it.next; oc_a = it.next;
    ob_wd = it.blocked; tk_wd = 1'b0; oc_wd = {idx_q, it.prev};
    q_pop_o = 1'b0;
    case (st_q)
      B_IDLE: begin
        if (!q_empty_i) begin
          if (it.load) begin
            ob_we = 1'b1; q_pop_o = 1'b1;
          end else begin
            st_d = B_RD; phase_d = 1'b0;
          end
        end
      end
      B_CLEAR: begin
        tk_a = addr_q; tk_we = 1'b1; tk_wd = 1'b0;
        if (init_q) begin
          ob_a = addr_q; ob_we = 1'b1; ob_wd = 1'b0;
        end
        addr_d = addr_q + CellW'(1);
        if (addr_q == CellW'(Cells-1)) begin
          st_d = B_IDLE; clr_d = 1'b0; init_d = 1'b0;
        end
      end
      B_RD: begin
        // address held on next; data returns after this edge
        st_d = B_WAIT;
      end
      B_WAIT: begin
        if (!phase_q) begin
          nblk_d = ob_rd; ntak_d = tk_rd; nown_d = oc_rd[AgentW+CellW-1:CellW];
          phase_d = 1'b1;
          tk_a = it.prev; oc_a = it.prev;
          st_d = B_EVAL;
        end
      end
      B_EVAL: begin
        tk_a = it.prev; oc_a = it.prev;
        idx_d = cnt_q; tm_d = it.tstamp; eos_d = it.last; oth_d = '0;
        if (fail_q) stat_d = ST_SKIPPED;
        else if (it.pre_status != ST_OK) stat_d = it.pre_status;
        else if (it.off_map || nblk_q) stat_d = ST_OBSTACLE;
        else if (ntak_q) begin stat_d = ST_VERTEX; oth_d = nown_q; end
        else if (tk_rd && oc_rd[CellW-1:0] == it.next) begin
          stat_d = ST_EDGE; oth_d = oc_rd[AgentW+CellW-1:CellW];
        end else stat_d = ST_OK;
        if (!fail_q && stat_d == ST_OK) begin
          tk_a = it.next; oc_a = it.next; tk_we = 1'b1; tk_wd = 1'b1; oc_we = 1'b1;
          oc_wd = {cnt_q, it.prev};
        end
        ok_d = it.last && !fail_q && stat_d == ST_OK;
        if (it.last) begin fail_d = 1'b0; cnt_d = '0; clr_d = 1'b1; end
        else begin fail_d = fail_q || stat_d != ST_OK; cnt_d = cnt_q + AgentW'(1); end
        q_pop_o = 1'b1;
        st_d = B_OUT;
      end
      B_OUT: begin
        if (m_tready_i) begin
          if (clr_q) begin st_d = B_CLEAR; addr_d = '0; end
          else st_d = B_IDLE;
        end
      end
      default: st_d = B_IDLE;
    endcase
  end

  assign m_tvalid_o = st_q == B_OUT;
  assign status_o = stat_q; assign agent_o = idx_q; assign other_o = oth_q;
  assign time_o = tm_q; assign eos_o = eos_q; assign ok_o = ok_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= B_CLEAR; addr_q <= '0; phase_q <= 1'b0; cnt_q <= '0; fail_q <= 1'b0;
      clr_q <= 1'b1; init_q <= 1'b1;
    end else begin
      st_q <= st_d; addr_q <= addr_d; phase_q <= phase_d; cnt_q <= cnt_d;
      fail_q <= fail_d; clr_q <= clr_d; init_q <= init_d;
    end
  end

  always_ff @(posedge clk_i) begin
    stat_q <= stat_d; oth_q <= oth_d; eos_q <= eos_d; ok_q <= ok_d; tm_q <= tm_d;
    idx_q <= idx_d; nblk_q <= nblk_d; ntak_q <= ntak_d; nown_q <= nown_d;
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == B_OUT && !m_tready_i) |=> st_q == B_OUT)
    else $error("result dropped while stalled");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == B_OUT) |-> !(ok_q && !eos_q))
    else $error("step ok outside end of step");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop_o |-> !q_empty_i)
    else $error("pop from empty queue");

endmodule

// ----- hdl/grid_agent_step_conflict_checker_top.sv -----
// Load items: a load item is written into the obstacle map by the table stage and gives no result;
// a transition result passes the classifier (serial column divide and queue hand-off), then
// the table stage states B_IDLE, B_RD, B_WAIT, B_EVAL and B_OUT.
// Flow: the classifier takes no new transfer until its current one is handed to the queue;
// the last agent of a step adds a sweep over all 4096 cells that clears the occupancy table.
// Reset: async active low; a sweep over all cells then clears the table and obstacle map.
// ----------------------------------------------------------------------------
// grid_agent_step_conflict_checker_top: step conflict checker
// Front classifier, item queue and table stage.
// ----------------------------------------------------------------------------
module grid_agent_step_conflict_checker_top
  import gasc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_tvalid,
  output logic        s_tready,
  // mode, prev_location, next_location, prev_heading, next_heading, cell_blocked,
  // step_time (bits 0..45), zero fill
  input  logic [47:0] s_tdata,
  input  logic        s_tlast,
  output logic        m_tvalid,
  input  logic        m_tready,
  // status, agent_index, other_agent, report_time, step_ok (bits 0..40), zero fill
  output logic [47:0] m_tdata,
  output logic        m_tlast,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [13:0] cfg_data_i
);

  logic [DimW-1:0] rows_q, cols_q;
  logic signed [OffW-1:0] off_q [4];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q <= DimW'(64); cols_q <= DimW'(64);
      off_q[0] <= OffW'(1); off_q[1] <= OffW'(64);
      off_q[2] <= -OffW'(1); off_q[3] <= -OffW'(64);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_ROWS: rows_q <= cfg_data_i[DimW-1:0];
        REG_COLS: cols_q <= cfg_data_i[DimW-1:0];
        REG_OFF0: off_q[0] <= cfg_data_i;
        REG_OFF1: off_q[1] <= cfg_data_i;
        REG_OFF2: off_q[2] <= cfg_data_i;
        REG_OFF3: off_q[3] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  item_t in_item, fq_item, bq_item;
  logic  f_valid, f_ready, q_full, q_empty, q_pop;

  always_comb begin
    in_item.load       = !s_tdata[0];
    in_item.prev       = s_tdata[12:1];
    in_item.next       = s_tdata[24:13];
    in_item.blocked    = s_tdata[29];
    in_item.tstamp     = s_tdata[45:30];
    in_item.last       = s_tlast;
    in_item.pre_status = ST_OK;
    in_item.off_map    = 1'b0;
  end

  gasc_front u_front (.clk_i, .rst_ni, .in_valid_i(s_tvalid), .in_ready_o(s_tready),
    .in_item_i(in_item), .ph_i(s_tdata[26:25]), .nh_i(s_tdata[28:27]),
    .rows_i(rows_q), .cols_i(cols_q), .off_i(off_q),
    .q_valid_o(f_valid), .q_ready_i(f_ready), .q_item_o(fq_item));

  assign f_ready = !q_full;

  gasc_queue u_queue (.clk_i, .rst_ni, .push_i(f_valid), .full_o(q_full),
    .data_i(fq_item), .pop_i(q_pop), .empty_o(q_empty), .data_o(bq_item));

  logic [3:0] st; logic [AgentW-1:0] ag, ot; logic [15:0] tm; logic ok;

  gasc_back u_back (.clk_i, .rst_ni, .q_empty_i(q_empty), .q_item_i(bq_item),
    .q_pop_o(q_pop), .m_tvalid_o(m_tvalid), .m_tready_i(m_tready),
    .status_o(st), .agent_o(ag), .other_o(ot), .time_o(tm), .eos_o(m_tlast), .ok_o(ok));

  assign m_tdata = {7'b0, ok, tm, ot, ag, st};

endmodule

// ----- dv/step_verdict_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// step_verdict_checker: verdict predictor and comparator
// Watches the item, result and register ports of the step checker, keeps its
// own obstacle map and occupancy table, predicts the verdict of every agent
// transfer and compares each result transfer against the oldest prediction.
// ----------------------------------------------------------------------------
module step_verdict_checker
  import gasc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [47:0] s_tdata,
  input  logic        s_tlast,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [47:0] m_tdata,
  input  logic        m_tlast,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [13:0] cfg_data_i,
  output int          pending_o,
  output int          errors_o
);

  typedef struct {
    status_e     st;
    logic [9:0]  idx;
    logic [9:0]  oth;
    logic [15:0] tm;
    logic        eos;
    logic        ok;
  } verdict_t;

  verdict_t verdict_q[$];

  logic             obstacle[Cells];
  logic             taken[Cells];
  logic [9:0]       owner[Cells];
  logic [CellW-1:0] came_from[Cells];
  logic [9:0]       agent_cnt;
  logic             failed;
  int               rows, cols;
  int               move_off[4];

  function automatic status_e judge_move(input logic [11:0] p, input logic [11:0] n,
                                         input logic [1:0] ph, input logic [1:0] nh,
                                         output logic [9:0] oth);
    int r, c, dr, dc;
    r   = (rows == 0) ? 1 : rows;
    c   = (cols == 0) ? 1 : cols;
    oth = '0;
    if (p == n) begin
      if (2'(ph - nh) == 2'd2) return ST_ROTATE;
    end else begin
      if (ph != nh) return ST_MOVE_ROT;
      if (int'(n) - int'(p) != move_off[ph]) return ST_WRONG_DIR;
      dr = int'(n) / c - int'(p) / c;
      dc = int'(n) % c - int'(p) % c;
      if ((dr < 0 ? -dr : dr) + (dc < 0 ? -dc : dc) > 1) return ST_TOO_FAR;
    end
    if (int'(n) >= r * c || obstacle[n]) return ST_OBSTACLE;
    if (taken[n]) begin
      oth = owner[n];
      return ST_VERTEX;
    end
    if (taken[p] && came_from[p] == n) begin
      oth = owner[p];
      return ST_EDGE;
    end
    return ST_OK;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("%0t mismatch %s: got %0d expected %0d", $realtime, what, got, want);
    errors_o++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    logic [11:0] p, n;
    logic [1:0]  ph, nh;
    verdict_t    v, w;
    if (!rst_ni) begin
      rows = 64;
      cols = 64;
      move_off[0] = 1;
      move_off[1] = 64;
      move_off[2] = -1;
      move_off[3] = -64;
      agent_cnt = '0;
      failed = 1'b0;
      for (int i = 0; i < Cells; i++) begin
        obstacle[i] = 1'b0;
        taken[i] = 1'b0;
      end
      verdict_q.delete();
    end else begin
      if (cfg_we_i) begin
        case (reg_e'(cfg_idx_i))
          REG_ROWS: rows = int'(cfg_data_i[6:0]);
          REG_COLS: cols = int'(cfg_data_i[6:0]);
          REG_OFF0: move_off[0] = int'($signed(cfg_data_i));
          REG_OFF1: move_off[1] = int'($signed(cfg_data_i));
          REG_OFF2: move_off[2] = int'($signed(cfg_data_i));
          REG_OFF3: move_off[3] = int'($signed(cfg_data_i));
          default: ;
        endcase
      end
      if (s_tvalid && s_tready) begin
        p  = s_tdata[12:1];
        n  = s_tdata[24:13];
        ph = s_tdata[26:25];
        nh = s_tdata[28:27];
        if (!s_tdata[0]) begin
          obstacle[n] = s_tdata[29];
        end else begin
          v.oth = '0;
          if (failed) begin
            v.st = ST_SKIPPED;
          end else begin
            v.st = judge_move(p, n, ph, nh, v.oth);
            if (v.st != ST_OK) begin
              failed = 1'b1;
            end else begin
              taken[n] = 1'b1;
              owner[n] = agent_cnt;
              came_from[n] = p;
            end
          end
          v.idx = agent_cnt;
          v.tm  = s_tdata[45:30];
          v.eos = s_tlast;
          v.ok  = s_tlast && !failed;
          verdict_q = {verdict_q, v};
          if (s_tlast) begin
            for (int i = 0; i < Cells; i++) taken[i] = 1'b0;
            agent_cnt = '0;
            failed = 1'b0;
          end else begin
            agent_cnt = agent_cnt + 10'd1;
          end
        end
      end
      if (m_tvalid && m_tready) begin
        if (verdict_q.size() == 0) begin
          report_mismatch("unexpected result, status", int'(m_tdata[3:0]), -1);
        end else begin
          w = verdict_q.pop_front();
          if (m_tdata[3:0] != w.st) report_mismatch("status", m_tdata[3:0], w.st);
          if (m_tdata[13:4] != w.idx) report_mismatch("agent_index", m_tdata[13:4], w.idx);
          if (m_tdata[23:14] != w.oth) report_mismatch("other_agent", m_tdata[23:14], w.oth);
          if (m_tdata[39:24] != w.tm) report_mismatch("report_time", m_tdata[39:24], w.tm);
          if (m_tlast != w.eos) report_mismatch("end_of_step", m_tlast, w.eos);
          if (m_tdata[40] != w.ok) report_mismatch("step_ok", m_tdata[40], w.ok);
        end
      end
    end
    pending_o = verdict_q.size();
  end

endmodule

// ----- dv/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: step conflict checker testbench
// Directed steps for every rule, then random joint steps of agents waiting,
// moving and swapping over several grid and offset settings, with obstacle
// loads and random stalls on both channels.
// ----------------------------------------------------------------------------
module tb_top;
  import gasc_pkg::*;

  localparam int IdleLimit = 20000;
  localparam int SweepWait = 4200;

  logic        clk_i;
  logic        rst_ni;
  logic        s_tvalid;
  logic        s_tready;
  logic [47:0] s_tdata;   // mode, prev, next, prev_heading, next_heading, blocked, time
  logic        s_tlast;
  logic        m_tvalid;
  logic        m_tready;
  logic [47:0] m_tdata;   // status, agent_index, other_agent, report_time, step_ok
  logic        m_tlast;
  logic        cfg_we_i;
  logic [2:0]  cfg_idx_i;
  logic [13:0] cfg_data_i;

  int pending, errors;
  int idle_cycles;
  int stall_left;
  bit quiet;

  // generator's copy of the grid setting
  int g_rows, g_cols;
  int g_off[4];

  grid_agent_step_conflict_checker_top dut (
    .clk_i, .rst_ni, .s_tvalid, .s_tready, .s_tdata, .s_tlast,
    .m_tvalid, .m_tready, .m_tdata, .m_tlast, .cfg_we_i, .cfg_idx_i, .cfg_data_i
  );

  step_verdict_checker u_checker (
    .clk_i, .rst_ni, .s_tvalid, .s_tready, .s_tdata, .s_tlast,
    .m_tvalid, .m_tready, .m_tdata, .m_tlast, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .pending_o(pending), .errors_o(errors)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // result side back-pressure in bursts
  always @(negedge clk_i) begin
    if (quiet) begin
      m_tready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
    end else if ($urandom_range(0, 2) == 0) begin
      m_tready <= 1'b0;
      stall_left = $urandom_range(1, 17);
    end else begin
      m_tready <= 1'b1;
      stall_left = $urandom_range(1, 30);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we_i) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= IdleLimit) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  task automatic push_item(input logic mode, input logic [11:0] p, input logic [11:0] n,
                           input logic [1:0] ph, input logic [1:0] nh, input logic blk,
                           input logic [15:0] tm, input logic lst);
    if (!quiet && $urandom_range(0, 4) == 0) begin
      s_tvalid = 1'b0;
      repeat ($urandom_range(1, 17)) @(negedge clk_i);
    end
    s_tdata  = {2'b00, tm, blk, nh, ph, n, p, mode};
    s_tlast  = lst;
    s_tvalid = 1'b1;
    do @(posedge clk_i); while (!s_tready);
    @(negedge clk_i);
  endtask

  task automatic agent(input int p, input int n, input int ph, input int nh, input bit lst);
    push_item(1'b1, 12'(p), 12'(n), 2'(ph), 2'(nh), 1'($urandom), 16'($urandom), lst);
  endtask

  task automatic load_cell(input int n, input bit blk);
    push_item(1'b0, 12'($urandom), 12'(n), 2'($urandom), 2'($urandom), blk,
              16'($urandom), 1'($urandom));
  endtask

  task automatic write_reg(input reg_e idx, input int val);
    @(negedge clk_i);
    cfg_we_i   = 1'b1;
    cfg_idx_i  = idx;
    cfg_data_i = 14'(val);
    @(negedge clk_i);
    cfg_we_i   = 1'b0;
  endtask

  // only between phases: drain results and let the clearing sweep finish
  task automatic settle();
    s_tvalid = 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (SweepWait) @(negedge clk_i);
  endtask

  task automatic set_grid(input int r, input int c, input int o0, input int o1,
                          input int o2, input int o3);
    settle();
    g_rows = r;
    g_cols = c;
    g_off  = '{o0, o1, o2, o3};
    write_reg(REG_ROWS, r);
    write_reg(REG_COLS, c);
    write_reg(REG_OFF0, o0);
    write_reg(REG_OFF1, o1);
    write_reg(REG_OFF2, o2);
    write_reg(REG_OFF3, o3);
  endtask

  // random joint steps; most agents wait or move forward, some try a swap
  task automatic run_steps(input int n_items);
    int done, nsz, area, p, n, ph, nh, kind, last_p, last_n;
    done = 0;
    area = ((g_rows == 0) ? 1 : g_rows) * ((g_cols == 0) ? 1 : g_cols);
    if (area > Cells) area = Cells;
    while (done < n_items) begin
      nsz = $urandom_range(1, 12);
      last_p = 0;
      last_n = 0;
      for (int k = 0; k < nsz; k++) begin
        if ($urandom_range(0, 7) == 0) begin
          if ($urandom_range(0, 5) == 0) load_cell($urandom_range(0, Cells - 1), 1'($urandom));
          else load_cell($urandom_range(0, area - 1), $urandom_range(0, 3) == 0);
        end
        kind = $urandom_range(0, 9);
        p  = $urandom_range(0, area - 1);
        ph = $urandom_range(0, 3);
        if (kind <= 3) begin
          n  = p;
          nh = (ph + (($urandom_range(0, 9) == 0) ? 2 : $urandom_range(0, 1) * 2 + 1 - 1 +
                ($urandom_range(0, 1) ? 0 : 3))) % 4;
        end else if (kind <= 7) begin
          n  = (p + g_off[ph]) & 12'hfff;
          nh = ph;
        end else if (kind == 8) begin
          p  = last_n;
          n  = last_p;
          nh = ph;
        end else begin
          p  = $urandom_range(0, Cells - 1);
          n  = $urandom_range(0, Cells - 1);
          nh = $urandom_range(0, 3);
        end
        agent(p, n, ph, nh, k == nsz - 1);
        last_p = p;
        last_n = n;
        done++;
      end
    end
  endtask

  initial begin
    rst_ni     = 1'b0;
    s_tvalid   = 1'b0;
    s_tdata    = '0;
    s_tlast    = 1'b0;
    cfg_we_i   = 1'b0;
    cfg_idx_i  = '0;
    cfg_data_i = '0;
    quiet      = 1'b0;
    g_rows     = 64;
    g_cols     = 64;
    g_off      = '{1, 64, -1, -64};
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    repeat (SweepWait) @(negedge clk_i);

    // directed: steps for each rule on the reset grid
    load_cell(10, 1'b1);
    load_cell(4095, 1'b1);
    agent(0, 1, 0, 0, 0);          // ok
    agent(2, 1, 2, 2, 0);          // vertex conflict with the first agent
    agent(5, 5, 0, 0, 1);          // skipped after the failure
    agent(0, 1, 0, 0, 0);
    agent(1, 0, 2, 2, 1);          // swap with the first agent
    agent(3, 3, 0, 2, 1);          // half turn while waiting
    agent(3, 4, 0, 1, 1);          // move and rotate
    agent(3, 4, 1, 1, 1);          // against the heading offset
    agent(63, 64, 0, 0, 1);        // wraps to the next row: too far
    agent(9, 10, 0, 0, 1);         // into an obstacle
    agent(4094, 4095, 0, 0, 1);
    agent(4095, 4095, 3, 3, 1);
    agent(0, 0, 3, 1, 1);          // half turn while waiting, rejected
    push_item(1'b1, 12'hfff, 12'hfff, 2'd3, 2'd3, 1'b1, 16'hffff, 1'b1);
    push_item(1'b1, 12'h000, 12'h000, 2'd0, 2'd0, 1'b0, 16'h0000, 1'b1);
    load_cell(10, 1'b0);
    agent(9, 10, 0, 0, 1);         // freed again

    set_grid(2, 64, 1, 64, -1, -64);
    agent(200, 200, 0, 0, 1);      // beyond the rows in use
    run_steps(120);

    set_grid(4, 5, 1, 5, -1, -5);
    run_steps(150);
    set_grid(0, 0, 8191, -8192, 0, 1);   // zero size counts as one
    run_steps(60);
    set_grid(127, 127, 1, 127, -1, -127);
    run_steps(120);
    set_grid(8, 8, -8, 1, 8, -1);
    run_steps(150);
    set_grid(3, 3, 4096, -4096, 3, -3);
    run_steps(80);
    set_grid(64, 64, 1, 64, -1, -64);
    quiet = 1'b1;
    run_steps(150);

    s_tvalid = 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (60) @(negedge clk_i);
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
hdl/gasc_pkg.sv
hdl/gasc_ram.sv
hdl/gasc_front.sv
hdl/gasc_queue.sv
hdl/gasc_back.sv
hdl/grid_agent_step_conflict_checker_top.sv
dv/step_verdict_checker.sv
dv/tb_top.sv
